FILE: rtl/lds_pkg.sv
// Package with the shared types and constants of the LED driver serial framer.
package lds_pkg;

    typedef enum logic [1:0] {
        CMD_FRAME = 2'd0,
        CMD_START = 2'd1,
        CMD_DATA  = 2'd2,
        CMD_END   = 2'd3
    } cmd_t;

    localparam int          QUEUE_DEPTH = 2;
    localparam int          BITS_W      = 12;
    localparam int          NBITS_W     = 4;
    localparam logic [2:0]  ID_COMMAND  = 3'b100;
    localparam logic [2:0]  ID_ADDRESS  = 3'b101;
    localparam logic [2:0]  SEL_NONE    = 3'b111;

    typedef struct packed {
        cmd_t       command;
        logic [2:0] chip_mask;
        logic [8:0] payload;
    } in_item_t;

    typedef struct packed {
        logic [2:0] select_n;
        logic       strobe_res;
        logic       data_bit;
        logic       error;
        logic       last;
    } out_item_t;

    // One classified request: an optional leading release, up to twelve
    // bits sent from the top of bits, then an optional trailing release.
    typedef struct packed {
        logic                pre_release;
        logic [2:0]          sel_n;
        logic [BITS_W-1:0]   bits;
        logic [NBITS_W-1:0]  nbits;
        logic                post_release;
        logic                error;
    } job_t;

endpackage

FILE: rtl/led_driver_serial_framer.sv
// Top level of the LED driver serial framer: front end, job queue and serializer.
// A transaction's first result passes a queue entry, the serializer's job registers
// and its output register. The serializer emits one result per cycle unless m_ready
// stalls it; a transaction has 1 (end, stray data) to 13 (command frame) results.
// The job queue lets the front accept new transactions while the serializer is busy.
// Reset (aresetn low, synchronous) closes any open write and empties the queue.
module led_driver_serial_framer #(
    parameter int QUEUE_DEPTH = lds_pkg::QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  lds_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output lds_pkg::out_item_t m_data
);

    lds_pkg::job_t front_job;
    lds_pkg::job_t queue_job;
    logic          front_valid;
    logic          queue_full;
    logic          queue_empty;
    logic          queue_pop;

    lds_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .job_valid (front_valid),
        .job_ready (!queue_full),
        .job       (front_job)
    );

    lds_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (front_valid),
        .push_data (front_job),
        .full      (queue_full),
        .pop       (queue_pop),
        .empty     (queue_empty),
        .pop_data  (queue_job)
    );

    lds_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (!queue_empty),
        .job       (queue_job),
        .job_pop   (queue_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // A step that clocks no bit must drive the data line low and release all chips.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.strobe_res |-> !m_data.data_bit && m_data.select_n == lds_pkg::SEL_NONE)
        else $error("unclocked step drives data or holds a select");

    // An error result is always the only and final result of its transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error |-> m_data.last && !m_data.strobe_res)
        else $error("error result is not a lone final step");

    // The front never accepts a transaction while the queue has no room.
    assert property (@(posedge aclk) disable iff (!aresetn)
        queue_full |-> !s_ready)
        else $error("transaction accepted into a full queue");

endmodule

FILE: rtl/lds_front.sv
// Front end: accepts requests, tracks the open write and classifies each into a job.
module lds_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  lds_pkg::in_item_t s_data,
    output logic             job_valid,
    input  logic             job_ready,
    output lds_pkg::job_t    job
);

    logic [2:0] held_reg, held_next;
    logic       open_reg, open_next;
    logic       accept;

    assign s_ready   = job_ready;
    assign job_valid = s_valid;
    assign accept    = s_valid && job_ready;

    always_comb begin
        job              = '0;
        job.sel_n        = ~s_data.chip_mask;
        held_next        = held_reg;
        open_next        = open_reg;
        unique case (s_data.command)
            lds_pkg::CMD_FRAME: begin
                job.bits         = {lds_pkg::ID_COMMAND, s_data.payload};
                job.nbits        = lds_pkg::NBITS_W'(12);
                job.post_release = 1'b1;
                held_next        = 3'b000;
                open_next        = 1'b0;
            end
            lds_pkg::CMD_START: begin
                job.pre_release  = open_reg;
                job.bits         = {lds_pkg::ID_ADDRESS, s_data.payload[6:0], 2'b00};
                job.nbits        = lds_pkg::NBITS_W'(10);
                held_next        = s_data.chip_mask;
                open_next        = 1'b1;
            end
            lds_pkg::CMD_DATA: begin
                if (open_reg) begin
                    job.sel_n = ~held_reg;
                    // Data goes out LSB first, so the byte is mirrored to the top.
                    for (int i = 0; i < 8; i++) begin
                        job.bits[lds_pkg::BITS_W-1-i] = s_data.payload[i];
                    end
                    job.nbits = lds_pkg::NBITS_W'(8);
                end else begin
                    job.post_release = 1'b1;
                    job.error        = 1'b1;
                end
            end
            lds_pkg::CMD_END: begin
                job.post_release = 1'b1;
                held_next        = 3'b000;
                open_next        = 1'b0;
            end
            default: begin
                job.post_release = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= 3'b000;
            open_reg <= 1'b0;
        end else if (accept) begin
            held_reg <= held_next;
            open_reg <= open_next;
        end
    end

endmodule

FILE: rtl/lds_queue.sv
// Short job queue between the front end and the serializer.
module lds_queue #(
    parameter int DEPTH = lds_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lds_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output lds_pkg::job_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lds_pkg::job_t    entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/lds_back.sv
// Back end: walks one job at a time and emits one serial step per cycle unless m_ready stalls it.
module lds_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               job_valid,
    input  lds_pkg::job_t      job,
    output logic               job_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output lds_pkg::out_item_t m_data
);

    logic                        active_reg, active_next;
    logic                        pre_reg, pre_next;
    logic [2:0]                  sel_reg, sel_next;
    logic [lds_pkg::BITS_W-1:0]  bits_reg, bits_next;
    logic [lds_pkg::NBITS_W-1:0] cnt_reg, cnt_next;
    logic                        post_reg, post_next;
    logic                        err_reg, err_next;
    logic                        m_valid_reg, m_valid_next;
    lds_pkg::out_item_t          m_data_reg, m_data_next;
    lds_pkg::out_item_t          step;
    logic                        advance, load;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The step the current job produces next.
    always_comb begin
        step = '0;
        if (pre_reg) begin
            step.select_n = lds_pkg::SEL_NONE;
            step.last     = (cnt_reg == '0) && !post_reg;
        end else if (cnt_reg != '0) begin
            step.select_n   = sel_reg;
            step.strobe_res = 1'b1;
            step.data_bit   = bits_reg[lds_pkg::BITS_W-1];
            step.last       = (cnt_reg == lds_pkg::NBITS_W'(1)) && !post_reg;
        end else begin
            step.select_n = lds_pkg::SEL_NONE;
            step.error    = err_reg;
            step.last     = 1'b1;
        end
    end

    assign advance = active_reg && (!m_valid_reg || m_ready);
    assign load    = job_valid && (!active_reg || (advance && step.last));
    assign job_pop = load;

    always_comb begin
        active_next  = active_reg;
        pre_next     = pre_reg;
        sel_next     = sel_reg;
        bits_next    = bits_reg;
        cnt_next     = cnt_reg;
        post_next    = post_reg;
        err_next     = err_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (advance) begin
            m_valid_next = 1'b1;
            m_data_next  = step;
            if (pre_reg) begin
                pre_next = 1'b0;
            end else if (cnt_reg != '0) begin
                bits_next = {bits_reg[lds_pkg::BITS_W-2:0], 1'b0};
                cnt_next  = cnt_reg - 1'b1;
            end else begin
                post_next = 1'b0;
            end
            if (step.last) begin
                active_next = 1'b0;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (load) begin
            active_next = 1'b1;
            pre_next    = job.pre_release;
            sel_next    = job.sel_n;
            bits_next   = job.bits;
            cnt_next    = job.nbits;
            post_next   = job.post_release;
            err_next    = job.error;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            pre_reg     <= 1'b0;
            cnt_reg     <= '0;
            post_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            active_reg  <= active_next;
            pre_reg     <= pre_next;
            cnt_reg     <= cnt_next;
            post_reg    <= post_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg    <= sel_next;
        bits_reg   <= bits_next;
        err_reg    <= err_next;
        m_data_reg <= m_data_next;
    end

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the LED driver serial framer with handshake stalls on both sides.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lds_pkg::*;

    localparam int          TOTAL_REQUESTS = 410;
    localparam int          DRAIN_AT       = 200;
    localparam int          HOLD_AT        = 300;
    localparam int          HOLD_CYCLES    = 200;
    localparam out_item_t   RELEASE_DONE   = '{SEL_NONE, 1'b0, 1'b0, 1'b0, 1'b1};
    localparam out_item_t   STRAY_DATA     = '{SEL_NONE, 1'b0, 1'b0, 1'b1, 1'b1};

    typedef struct {
        in_item_t  req;
        bit        typed;
        out_item_t result;
    } directed_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    // Shadow of the framer state, advanced at each accepted request.
    logic [2:0] held_selects;
    logic       write_open;

    out_item_t     step_out[$];
    out_item_t     expected_bits[$];
    directed_row_t directed[$];

    int requests_sent;
    int results_checked;
    int writes_opened;
    int stray_errors;
    int mismatches;

    led_driver_serial_framer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    function automatic void emit(input logic [2:0] sel_n, input logic strobe,
                                 input logic bit_val, input logic err);
        out_item_t r;
        r.select_n   = sel_n;
        r.strobe_res = strobe;
        r.data_bit   = bit_val;
        r.error      = err;
        r.last       = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void emit_msb(input logic [2:0] sel_n, input logic [11:0] word,
                                     input int count);
        for (int i = count - 1; i >= 0; i--) begin
            emit(sel_n, 1'b1, word[i], 1'b0);
        end
    endfunction

    // Builds the bit sequence that one request produces and updates the shadow state.
    function automatic void serialize_request(input in_item_t req);
        step_out.delete();
        case (req.command)
            CMD_FRAME: begin
                emit_msb(~req.chip_mask, {ID_COMMAND, req.payload}, 12);
                emit(SEL_NONE, 1'b0, 1'b0, 1'b0);
                held_selects = 3'd0;
                write_open   = 1'b0;
            end
            CMD_START: begin
                if (write_open) begin
                    emit(SEL_NONE, 1'b0, 1'b0, 1'b0);
                end
                emit_msb(~req.chip_mask, {2'b00, ID_ADDRESS, req.payload[6:0]}, 10);
                held_selects = req.chip_mask;
                write_open   = 1'b1;
            end
            CMD_DATA: begin
                if (write_open) begin
                    for (int i = 0; i < 8; i++) begin
                        emit(~held_selects, 1'b1, req.payload[i], 1'b0);
                    end
                end else begin
                    emit(SEL_NONE, 1'b0, 1'b0, 1'b1);
                end
            end
            default: begin
                emit(SEL_NONE, 1'b0, 1'b0, 1'b0);
                held_selects = 3'd0;
                write_open   = 1'b0;
            end
        endcase
        step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    function automatic in_item_t make_request(input cmd_t cmd, input logic [2:0] mask,
                                              input logic [8:0] pay);
        in_item_t r;
        r.command   = cmd;
        r.chip_mask = mask;
        r.payload   = pay;
        return r;
    endfunction

    function automatic in_item_t random_request(input cmd_t cmd);
        return make_request(cmd, 3'($urandom_range(0, 7)), 9'($urandom_range(0, 511)));
    endfunction

    task automatic add_row(input cmd_t cmd, input logic [2:0] mask, input logic [8:0] pay,
                           input bit typed, input out_item_t result);
        directed_row_t row;
        row.req    = make_request(cmd, mask, pay);
        row.typed  = typed;
        row.result = result;
        directed.push_back(row);
    endtask

    // Offers one request and holds it until the front accepts it. A typed result
    // replaces the predicted sequence; the shadow state is advanced either way.
    task automatic send_request(input in_item_t req, input bit typed, input out_item_t result,
                                input bit drain);
        int gap;
        if ((requests_sent / 30) % 3 == 0) begin
            gap = 0;
        end else begin
            gap = $urandom_range(0, 9);
        end
        // Valid only drops when at least one clock edge passes before it rises again.
        if (gap > 0 || (drain && expected_bits.size() != 0)) begin
            s_valid <= 1'b0;
        end
        while (drain && expected_bits.size() != 0) begin
            @(posedge aclk);
        end
        repeat (gap) @(posedge aclk);
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (req.command == CMD_START) begin
            writes_opened++;
        end
        if (req.command == CMD_DATA && !write_open) begin
            stray_errors++;
        end
        serialize_request(req);
        if (typed) begin
            expected_bits.push_back(result);
        end else begin
            foreach (step_out[i]) begin
                expected_bits.push_back(step_out[i]);
            end
        end
        requests_sent++;
    endtask

    // Result consumer: random stalls, fast stretches, and one long hold to back up the queue.
    initial begin
        int stall;
        int taken;
        m_ready = 1'b0;
        taken   = 0;
        forever begin
            if (taken == HOLD_AT) begin
                stall = HOLD_CYCLES;
            end else if ((taken / 64) % 3 == 1) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 9);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && aresetn)) begin
                @(posedge aclk);
            end
            taken++;
        end
    end

    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_bits.size() == 0) begin
                $error({"unexpected result: select_n=%0d strobe_res=%0d data_bit=%0d",
                        " error=%0d last=%0d"},
                       m_data.select_n, m_data.strobe_res, m_data.data_bit, m_data.error,
                       m_data.last);
                mismatches++;
            end else begin
                want = expected_bits.pop_front();
                if (m_data.select_n !== want.select_n) begin
                    $error("select_n: expected %0d, got %0d", want.select_n, m_data.select_n);
                    mismatches++;
                end
                if (m_data.strobe_res !== want.strobe_res) begin
                    $error("strobe_res: expected %0d, got %0d", want.strobe_res,
                           m_data.strobe_res);
                    mismatches++;
                end
                if (m_data.data_bit !== want.data_bit) begin
                    $error("data_bit: expected %0d, got %0d", want.data_bit, m_data.data_bit);
                    mismatches++;
                end
                if (m_data.error !== want.error) begin
                    $error("error: expected %0d, got %0d", want.error, m_data.error);
                    mismatches++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_data.last);
                    mismatches++;
                end
            end
            results_checked++;
        end
    end

    initial begin
        #2_000_000;
        $display("led_driver_serial_framer verification failed");
        $finish;
    end

    initial begin
        int n_data;
        int closer;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_data          = '0;
        held_selects    = 3'd0;
        write_open      = 1'b0;
        requests_sent   = 0;
        results_checked = 0;
        writes_opened   = 0;
        stray_errors    = 0;
        mismatches      = 0;

        // Stray data and end right after reset, then frames at the field extremes,
        // an empty mask, ignored high bits, a restart and a command inside an open write.
        add_row(CMD_DATA,  3'd7, 9'h1FF, 1'b1, STRAY_DATA);
        add_row(CMD_END,   3'd7, 9'h000, 1'b1, RELEASE_DONE);
        add_row(CMD_FRAME, 3'd7, 9'h1FF, 1'b0, RELEASE_DONE);
        add_row(CMD_FRAME, 3'd0, 9'h000, 1'b0, RELEASE_DONE);
        add_row(CMD_START, 3'd5, 9'h1FF, 1'b0, RELEASE_DONE);
        add_row(CMD_DATA,  3'd0, 9'h1FF, 1'b0, RELEASE_DONE);
        add_row(CMD_DATA,  3'd7, 9'h0AA, 1'b0, RELEASE_DONE);
        add_row(CMD_START, 3'd2, 9'h000, 1'b0, RELEASE_DONE);
        add_row(CMD_DATA,  3'd4, 9'h055, 1'b0, RELEASE_DONE);
        add_row(CMD_FRAME, 3'd1, 9'h155, 1'b0, RELEASE_DONE);
        add_row(CMD_DATA,  3'd3, 9'h100, 1'b1, STRAY_DATA);
        add_row(CMD_START, 3'd0, 9'h07F, 1'b0, RELEASE_DONE);
        add_row(CMD_DATA,  3'd6, 9'h080, 1'b0, RELEASE_DONE);
        add_row(CMD_END,   3'd0, 9'h1FF, 1'b1, RELEASE_DONE);
        add_row(CMD_END,   3'd5, 9'h0F0, 1'b1, RELEASE_DONE);
        add_row(CMD_START, 3'd7, 9'h180, 1'b0, RELEASE_DONE);
        add_row(CMD_DATA,  3'd1, 9'h001, 1'b0, RELEASE_DONE);
        add_row(CMD_DATA,  3'd2, 9'h000, 1'b0, RELEASE_DONE);
        add_row(CMD_END,   3'd3, 9'h0AB, 1'b1, RELEASE_DONE);
        add_row(CMD_DATA,  3'd0, 9'h0F0, 1'b1, STRAY_DATA);
        add_row(CMD_FRAME, 3'd6, 9'h0CC, 1'b0, RELEASE_DONE);

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) begin
            send_request(directed[i].req, directed[i].typed, directed[i].result, 1'b0);
        end

        // Mostly complete writes with random content; the rest is arbitrary traffic.
        while (requests_sent < TOTAL_REQUESTS) begin
            if ($urandom_range(0, 4) != 0) begin
                send_request(random_request(CMD_START), 1'b0, RELEASE_DONE,
                             requests_sent == DRAIN_AT);
                n_data = $urandom_range(0, 6);
                repeat (n_data) begin
                    send_request(random_request(CMD_DATA), 1'b0, RELEASE_DONE,
                                 requests_sent == DRAIN_AT);
                end
                closer = $urandom_range(0, 5);
                if (closer <= 3) begin
                    send_request(random_request(CMD_END), 1'b0, RELEASE_DONE,
                                 requests_sent == DRAIN_AT);
                end else if (closer == 4) begin
                    send_request(random_request(CMD_FRAME), 1'b0, RELEASE_DONE,
                                 requests_sent == DRAIN_AT);
                end
            end else begin
                send_request(random_request(cmd_t'($urandom_range(0, 3))), 1'b0,
                             RELEASE_DONE, requests_sent == DRAIN_AT);
            end
        end
        s_valid <= 1'b0;

        while (expected_bits.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);

        $display("Run covered %0d requests and %0d serial results, with %0d writes opened",
                 requests_sent, results_checked, writes_opened);
        $display("and %0d stray data bytes flagged; %0d field mismatches seen.",
                 stray_errors, mismatches);
        if (mismatches == 0 && expected_bits.size() == 0) begin
            $display("led_driver_serial_framer verification clean");
        end else begin
            $display("led_driver_serial_framer verification failed");
        end
        $finish;
    end

endmodule
